[hw/rtl/sst_pkg.sv]
// ============================================================================
// sst_pkg: shared types, constants and decode helpers for the tokenizer
// Field widths, token kinds, scan modes, record layout, character classes.
// ============================================================================
package sst_pkg;

  // Field widths
  localparam int POSITION_BITS = 24;
  localparam int LINE_BITS     = 20;
  localparam int LENGTH_BITS   = 16;
  localparam int COLUMN_BITS   = 16;
  localparam int KIND_BITS     = 6;
  localparam int ERR_BITS      = 2;
  localparam int CHAR_BITS     = 8;

  // Stream payload widths
  localparam int M_FIELD_BITS  = LINE_BITS + COLUMN_BITS + POSITION_BITS + LENGTH_BITS
                                 + ERR_BITS;
  localparam int M_TDATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

  // Output record queue
  localparam int REC_FIFO_DEPTH = 4;
  localparam int REC_PTR_BITS   = $clog2(REC_FIFO_DEPTH);
  localparam int REC_CNT_BITS   = $clog2(REC_FIFO_DEPTH + 1);

  // Request types
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_START_LINE   = 1'b0;
  localparam logic CFG_START_COLUMN = 1'b1;

  // Error codes
  localparam logic [ERR_BITS-1:0] ERR_NONE         = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_ILLEGAL      = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_NL_IN_STRING = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_UNCLOSED     = 2'd3;

  // Token kinds
  localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd0;
  localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd1;
  localparam logic [KIND_BITS-1:0] K_LBRACKET = 6'd2;
  localparam logic [KIND_BITS-1:0] K_RBRACKET = 6'd3;
  localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd4;
  localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd5;
  localparam logic [KIND_BITS-1:0] K_OR_OR    = 6'd6;
  localparam logic [KIND_BITS-1:0] K_GE       = 6'd7;
  localparam logic [KIND_BITS-1:0] K_GT       = 6'd8;
  localparam logic [KIND_BITS-1:0] K_EQ_EQ    = 6'd9;
  localparam logic [KIND_BITS-1:0] K_ASSIGN   = 6'd10;
  localparam logic [KIND_BITS-1:0] K_LE       = 6'd11;
  localparam logic [KIND_BITS-1:0] K_LT       = 6'd12;
  localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd13;
  localparam logic [KIND_BITS-1:0] K_COLON    = 6'd14;
  localparam logic [KIND_BITS-1:0] K_COMMENT  = 6'd15;
  localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd16;
  localparam logic [KIND_BITS-1:0] K_DOT      = 6'd17;
  localparam logic [KIND_BITS-1:0] K_DEC      = 6'd18;
  localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd19;
  localparam logic [KIND_BITS-1:0] K_INC      = 6'd20;
  localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd21;
  localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd22;
  localparam logic [KIND_BITS-1:0] K_STAR     = 6'd23;
  localparam logic [KIND_BITS-1:0] K_AND_AND  = 6'd24;
  localparam logic [KIND_BITS-1:0] K_PERCENT  = 6'd25;
  localparam logic [KIND_BITS-1:0] K_NE       = 6'd26;
  localparam logic [KIND_BITS-1:0] K_NOT      = 6'd27;
  localparam logic [KIND_BITS-1:0] K_STRING   = 6'd28;
  localparam logic [KIND_BITS-1:0] K_NUMBER   = 6'd29;
  localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd30;
  localparam logic [KIND_BITS-1:0] K_ERROR    = 6'd31;
  localparam logic [KIND_BITS-1:0] K_END      = 6'd32;

  // Characters
  localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_BITS-1:0] CH_SQUOTE = 8'h27;

  // Scanner modes; operator modes follow the operator table order
  typedef enum logic [4:0] {
    MODE_IDLE    = 5'd0,
    MODE_BAR     = 5'd1,
    MODE_GT      = 5'd2,
    MODE_EQ      = 5'd3,
    MODE_LT      = 5'd4,
    MODE_SLASH   = 5'd5,
    MODE_MINUS   = 5'd6,
    MODE_PLUS    = 5'd7,
    MODE_AMP     = 5'd8,
    MODE_BANG    = 5'd9,
    MODE_COMMENT = 5'd10,
    MODE_STRING  = 5'd11,
    MODE_INT     = 5'd12,
    MODE_FRAC    = 5'd13,
    MODE_IDENT   = 5'd14
  } scan_mode_t;

  // One result record
  typedef struct packed {
    logic                     last;
    logic [KIND_BITS-1:0]     kind;
    logic [LINE_BITS-1:0]     line;
    logic [COLUMN_BITS-1:0]   column;
    logic [POSITION_BITS-1:0] position;
    logic [LENGTH_BITS-1:0]   length;
    logic [ERR_BITS-1:0]      error;
  } rec_t;

  // Configuration write request
  typedef struct packed {
    logic                 we;
    logic                 index;
    logic [LINE_BITS-1:0] data;
  } cfg_wr_t;

  // Single-character token lookup
  typedef struct packed {
    logic                 hit;
    logic [KIND_BITS-1:0] kind;
  } char_kind_t;

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_ident_start(input logic [CHAR_BITS-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
  endfunction

  // Operator lead character -> operator mode
  function automatic scan_mode_t lead_mode(input logic [CHAR_BITS-1:0] c);
    scan_mode_t m;
    case (c)
      "|":     m = MODE_BAR;
      ">":     m = MODE_GT;
      "=":     m = MODE_EQ;
      "<":     m = MODE_LT;
      "/":     m = MODE_SLASH;
      "-":     m = MODE_MINUS;
      "+":     m = MODE_PLUS;
      "&":     m = MODE_AMP;
      "!":     m = MODE_BANG;
      default: m = MODE_IDLE;
    endcase
    return m;
  endfunction

  function automatic logic [CHAR_BITS-1:0] op_second(input scan_mode_t m);
    logic [CHAR_BITS-1:0] s;
    case (m)
      MODE_BAR:   s = "|";
      MODE_SLASH: s = "/";
      MODE_MINUS: s = "-";
      MODE_PLUS:  s = "+";
      MODE_AMP:   s = "&";
      default:    s = "=";
    endcase
    return s;
  endfunction

  function automatic logic [KIND_BITS-1:0] op_pair_kind(input scan_mode_t m);
    logic [KIND_BITS-1:0] k;
    case (m)
      MODE_BAR:   k = K_OR_OR;
      MODE_GT:    k = K_GE;
      MODE_EQ:    k = K_EQ_EQ;
      MODE_LT:    k = K_LE;
      MODE_SLASH: k = K_COMMENT;
      MODE_MINUS: k = K_DEC;
      MODE_PLUS:  k = K_INC;
      MODE_AMP:   k = K_AND_AND;
      MODE_BANG:  k = K_NE;
      default:    k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_BITS-1:0] op_single_kind(input scan_mode_t m);
    logic [KIND_BITS-1:0] k;
    case (m)
      MODE_GT:    k = K_GT;
      MODE_EQ:    k = K_ASSIGN;
      MODE_LT:    k = K_LT;
      MODE_SLASH: k = K_SLASH;
      MODE_MINUS: k = K_MINUS;
      MODE_PLUS:  k = K_PLUS;
      MODE_BANG:  k = K_NOT;
      default:    k = K_ERROR;  // lone bar or ampersand
    endcase
    return k;
  endfunction

  function automatic char_kind_t single_char_kind(input logic [CHAR_BITS-1:0] c);
    char_kind_t r;
    r.hit = 1'b1;
    case (c)
      "{":     r.kind = K_LBRACE;
      "}":     r.kind = K_RBRACE;
      "[":     r.kind = K_LBRACKET;
      "]":     r.kind = K_RBRACKET;
      "(":     r.kind = K_LPAREN;
      ")":     r.kind = K_RPAREN;
      ";":     r.kind = K_SEMI;
      ":":     r.kind = K_COLON;
      ".":     r.kind = K_DOT;
      ",":     r.kind = K_COMMA;
      "*":     r.kind = K_STAR;
      "%":     r.kind = K_PERCENT;
      default: begin
        r.hit  = 1'b0;
        r.kind = K_ERROR;
      end
    endcase
    return r;
  endfunction

  // Saturating increments
  function automatic logic [LINE_BITS-1:0] sat_inc_line(input logic [LINE_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [COLUMN_BITS-1:0] sat_inc_col(input logic [COLUMN_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [POSITION_BITS-1:0] sat_inc_pos(
      input logic [POSITION_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat_inc_len(input logic [LENGTH_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

[hw/rtl/sst_scan.sv]
// ============================================================================
// sst_scan: tokenizer state and single-pass step logic
// Holds position/line/column tracking and the scan mode; turns one request
// into zero, one or two records combinationally from the current state.
// ============================================================================
module sst_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step_en,
  input  logic                          req_type,
  input  logic [sst_pkg::CHAR_BITS-1:0] char_byte,
  input  sst_pkg::cfg_wr_t              cfg,
  output sst_pkg::rec_t                 rec0,
  output sst_pkg::rec_t                 rec1,
  output logic [1:0]                    rec_count
);

  // State
  sst_pkg::scan_mode_t                  mode;
  logic                                 quote_kind;
  logic                                 cr_seen;
  logic [sst_pkg::ERR_BITS-1:0]         sticky;
  logic [sst_pkg::LINE_BITS-1:0]        pend_line;
  logic [sst_pkg::COLUMN_BITS-1:0]      pend_col;
  logic [sst_pkg::POSITION_BITS-1:0]    pend_pos;
  logic [sst_pkg::LENGTH_BITS-1:0]      pend_len;
  logic [sst_pkg::LINE_BITS-1:0]        cur_line;
  logic [sst_pkg::COLUMN_BITS-1:0]      cur_col;
  logic [sst_pkg::POSITION_BITS-1:0]    cur_pos;
  logic [sst_pkg::LINE_BITS-1:0]        start_line;
  logic [sst_pkg::COLUMN_BITS-1:0]      start_col;

  // Byte decode
  logic                                 is_end;
  logic                                 crlf_skip;
  logic                                 is_nl;
  logic [sst_pkg::CHAR_BITS-1:0]        c;
  logic [sst_pkg::LINE_BITS-1:0]        byte_line;
  logic [sst_pkg::COLUMN_BITS-1:0]      byte_col;

  // Token start decode
  sst_pkg::scan_mode_t                  b_lead;
  sst_pkg::char_kind_t                  b_ck;
  logic                                 b_ws;
  logic                                 b_quote;
  sst_pkg::scan_mode_t                  b_mode;
  logic                                 b_emit;
  logic [sst_pkg::LENGTH_BITS-1:0]      b_plen;

  // Step control
  sst_pkg::scan_mode_t                  mode_next;
  logic                                 is_op_mode;
  logic                                 emit_pend;
  logic [sst_pkg::KIND_BITS-1:0]        pend_kind;
  logic [sst_pkg::LENGTH_BITS-1:0]      pend_rec_len;
  logic                                 do_begin;
  logic                                 len_inc;
  logic                                 len_two;
  logic [sst_pkg::ERR_BITS-1:0]         err_next;

  sst_pkg::rec_t                        pend_rec;
  sst_pkg::rec_t                        begin_rec;
  sst_pkg::rec_t                        end_rec;
  sst_pkg::rec_t                        second_rec;
  logic                                 has_second;

  always_comb begin
    is_end    = (req_type == sst_pkg::REQ_END);
    crlf_skip = !is_end && cr_seen && (char_byte == sst_pkg::CH_LF);
    is_nl     = (char_byte == sst_pkg::CH_CR) || (char_byte == sst_pkg::CH_LF);
    c         = is_nl ? sst_pkg::CH_LF : char_byte;
    byte_line = is_nl ? sst_pkg::sat_inc_line(cur_line) : cur_line;
    byte_col  = is_nl ? '0 : sst_pkg::sat_inc_col(cur_col);

    b_lead  = sst_pkg::lead_mode(c);
    b_ck    = sst_pkg::single_char_kind(c);
    b_ws    = (c == sst_pkg::CH_SPACE) || (c == sst_pkg::CH_TAB) || (c == sst_pkg::CH_LF);
    b_quote = (c == sst_pkg::CH_DQUOTE) || (c == sst_pkg::CH_SQUOTE);
    b_plen  = b_quote ? '0 : sst_pkg::LENGTH_BITS'(1);
    b_emit  = 1'b0;
    if (b_ws) begin
      b_mode = sst_pkg::MODE_IDLE;
    end else if (b_lead != sst_pkg::MODE_IDLE) begin
      b_mode = b_lead;
    end else if (b_ck.hit) begin
      b_mode = sst_pkg::MODE_IDLE;
      b_emit = 1'b1;
    end else if (b_quote) begin
      b_mode = sst_pkg::MODE_STRING;
    end else if (sst_pkg::is_digit(c)) begin
      b_mode = sst_pkg::MODE_INT;
    end else if (sst_pkg::is_ident_start(c)) begin
      b_mode = sst_pkg::MODE_IDENT;
    end else begin
      b_mode = sst_pkg::MODE_IDLE;  // unknown byte: zero-length error token
      b_emit = 1'b1;
    end
  end

  // Next-state logic
  always_comb begin
    is_op_mode   = (mode >= sst_pkg::MODE_BAR) && (mode <= sst_pkg::MODE_BANG);
    mode_next    = mode;
    emit_pend    = 1'b0;
    pend_kind    = sst_pkg::K_ERROR;
    pend_rec_len = pend_len;
    do_begin     = 1'b0;
    len_inc      = 1'b0;
    len_two      = 1'b0;
    err_next     = sticky;
    if (is_end) begin
      mode_next = sst_pkg::MODE_IDLE;
      emit_pend = (mode != sst_pkg::MODE_IDLE);
      if (is_op_mode) begin
        pend_kind    = sst_pkg::op_single_kind(mode);
        pend_rec_len = sst_pkg::LENGTH_BITS'(1);
        if (pend_kind == sst_pkg::K_ERROR) begin
          err_next = sst_pkg::ERR_ILLEGAL;
        end
      end else begin
        case (mode)
          sst_pkg::MODE_COMMENT: pend_kind = sst_pkg::K_COMMENT;
          sst_pkg::MODE_STRING: begin
            pend_kind = sst_pkg::K_ERROR;
            err_next  = sst_pkg::ERR_UNCLOSED;
          end
          sst_pkg::MODE_INT,
          sst_pkg::MODE_FRAC:   pend_kind = sst_pkg::K_NUMBER;
          sst_pkg::MODE_IDENT:  pend_kind = sst_pkg::K_IDENT;
          default:              pend_kind = sst_pkg::K_ERROR;
        endcase
      end
    end else if (!crlf_skip) begin
      if (is_op_mode) begin
        if (c == sst_pkg::op_second(mode)) begin
          if (mode == sst_pkg::MODE_SLASH) begin
            mode_next = sst_pkg::MODE_COMMENT;
            len_two   = 1'b1;
          end else begin
            emit_pend    = 1'b1;
            pend_kind    = sst_pkg::op_pair_kind(mode);
            pend_rec_len = sst_pkg::LENGTH_BITS'(2);
            mode_next    = sst_pkg::MODE_IDLE;
          end
        end else begin
          emit_pend    = 1'b1;
          pend_kind    = sst_pkg::op_single_kind(mode);
          pend_rec_len = sst_pkg::LENGTH_BITS'(1);
          if (pend_kind == sst_pkg::K_ERROR) begin
            err_next = sst_pkg::ERR_ILLEGAL;
          end
          do_begin = 1'b1;
        end
      end else begin
        case (mode)
          sst_pkg::MODE_COMMENT: begin
            if (c == sst_pkg::CH_LF) begin
              emit_pend = 1'b1;
              pend_kind = sst_pkg::K_COMMENT;
              mode_next = sst_pkg::MODE_IDLE;
            end else begin
              len_inc = 1'b1;
            end
          end
          sst_pkg::MODE_STRING: begin
            if (c == sst_pkg::CH_LF) begin
              err_next  = sst_pkg::ERR_NL_IN_STRING;
              emit_pend = 1'b1;
              pend_kind = sst_pkg::K_ERROR;
              mode_next = sst_pkg::MODE_IDLE;
            end else if (c == (quote_kind ? sst_pkg::CH_DQUOTE : sst_pkg::CH_SQUOTE)) begin
              emit_pend = 1'b1;
              pend_kind = sst_pkg::K_STRING;
              mode_next = sst_pkg::MODE_IDLE;
            end else begin
              len_inc = 1'b1;
            end
          end
          sst_pkg::MODE_INT,
          sst_pkg::MODE_FRAC: begin
            if (sst_pkg::is_digit(c) ||
                ((mode == sst_pkg::MODE_INT) && (c == sst_pkg::CH_DOT))) begin
              len_inc = 1'b1;
              if (c == sst_pkg::CH_DOT) begin
                mode_next = sst_pkg::MODE_FRAC;
              end
            end else begin
              emit_pend = 1'b1;
              pend_kind = sst_pkg::K_NUMBER;
              do_begin  = 1'b1;
            end
          end
          sst_pkg::MODE_IDENT: begin
            if (sst_pkg::is_ident_start(c) || sst_pkg::is_digit(c)) begin
              len_inc = 1'b1;
            end else begin
              emit_pend = 1'b1;
              pend_kind = sst_pkg::K_IDENT;
              do_begin  = 1'b1;
            end
          end
          default: do_begin = 1'b1;
        endcase
      end
      if (do_begin) begin
        mode_next = b_mode;
      end
    end
  end

  // Record outputs
  always_comb begin
    pend_rec = '{last: 1'b0, kind: pend_kind, line: pend_line, column: pend_col,
                 position: pend_pos, length: pend_rec_len, error: err_next};
    begin_rec = '{last: 1'b0, kind: b_ck.hit ? b_ck.kind : sst_pkg::K_ERROR,
                  line: byte_line, column: byte_col, position: cur_pos,
                  length: b_ck.hit ? sst_pkg::LENGTH_BITS'(1) : '0, error: err_next};
    end_rec = '{last: 1'b0, kind: sst_pkg::K_END, line: cur_line,
                column: sst_pkg::sat_inc_col(cur_col), position: cur_pos,
                length: '0, error: err_next};
    second_rec = is_end ? end_rec : begin_rec;
    has_second = is_end || (do_begin && b_emit);
    if (emit_pend) begin
      rec0      = pend_rec;
      rec1      = second_rec;
      rec_count = has_second ? 2'd2 : 2'd1;
    end else begin
      rec0      = second_rec;
      rec1      = second_rec;
      rec_count = has_second ? 2'd1 : 2'd0;
    end
    rec0.last = (rec_count == 2'd1);
    rec1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sst_pkg::MODE_IDLE;
      quote_kind <= 1'b0;
      cr_seen    <= 1'b0;
      sticky     <= sst_pkg::ERR_NONE;
      pend_line  <= '0;
      pend_col   <= '0;
      pend_pos   <= '0;
      pend_len   <= '0;
      cur_line   <= sst_pkg::LINE_BITS'(1);
      cur_col    <= '0;
      cur_pos    <= '0;
      start_line <= sst_pkg::LINE_BITS'(1);
      start_col  <= '0;
    end else begin
      if (step_en) begin
        if (is_end) begin
          // restart from the configured origin
          mode       <= sst_pkg::MODE_IDLE;
          quote_kind <= 1'b0;
          cr_seen    <= 1'b0;
          sticky     <= sst_pkg::ERR_NONE;
          pend_line  <= '0;
          pend_col   <= '0;
          pend_pos   <= '0;
          pend_len   <= '0;
          cur_line   <= start_line;
          cur_col    <= start_col;
          cur_pos    <= '0;
        end else if (crlf_skip) begin
          cr_seen <= 1'b0;
          cur_pos <= sst_pkg::sat_inc_pos(cur_pos);
        end else begin
          cr_seen  <= (char_byte == sst_pkg::CH_CR);
          cur_pos  <= sst_pkg::sat_inc_pos(cur_pos);
          cur_line <= byte_line;
          cur_col  <= byte_col;
          mode     <= mode_next;
          sticky   <= err_next;
          if (do_begin) begin
            pend_line <= byte_line;
            pend_col  <= byte_col;
            pend_pos  <= cur_pos;
            pend_len  <= b_plen;
            if (b_quote) begin
              quote_kind <= (c == sst_pkg::CH_DQUOTE);
            end
          end else if (len_two) begin
            pend_len <= sst_pkg::LENGTH_BITS'(2);
          end else if (len_inc) begin
            pend_len <= sst_pkg::sat_inc_len(pend_len);
          end
        end
      end
      if (cfg.we) begin
        if (cfg.index == sst_pkg::CFG_START_LINE) begin
          start_line <= cfg.data;
          if (cur_pos == '0) begin
            cur_line <= cfg.data;
          end
        end else begin
          start_col <= cfg.data[sst_pkg::COLUMN_BITS-1:0];
          if (cur_pos == '0) begin
            cur_col <= cfg.data[sst_pkg::COLUMN_BITS-1:0];
          end
        end
      end
    end
  end

  // Assertions
  a_rec_count_max: assert property (@(posedge clk) disable iff (rst)
    step_en |-> (rec_count != 2'd3))
    else $error("scan produced more than two records");

  a_end_single: assert property (@(posedge clk) disable iff (rst)
    (step_en && is_end && (rec_count == 2'd1)) |-> (rec0.kind == sst_pkg::K_END))
    else $error("lone end record has wrong kind");

  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    (step_en && is_end && !cfg.we) |=> ((cur_pos == '0) && (mode == sst_pkg::MODE_IDLE)
                                        && (sticky == sst_pkg::ERR_NONE)))
    else $error("end request did not restart scanner");

endmodule

[hw/rtl/sst_rec_fifo.sv]
// ============================================================================
// sst_rec_fifo: output record queue
// Takes up to two records per cycle, hands out one per cycle while out_ready is high.
// ============================================================================
module sst_rec_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_n,
  input  sst_pkg::rec_t in_rec0,
  input  sst_pkg::rec_t in_rec1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output sst_pkg::rec_t out_rec
);

  sst_pkg::rec_t                     mem [sst_pkg::REC_FIFO_DEPTH];
  logic [sst_pkg::REC_PTR_BITS-1:0]  wr_ptr;
  logic [sst_pkg::REC_PTR_BITS-1:0]  rd_ptr;
  logic [sst_pkg::REC_CNT_BITS-1:0]  count;
  logic [sst_pkg::REC_CNT_BITS-1:0]  count_next;
  logic                              pop;

  assign out_valid  = (count != '0);
  assign out_rec    = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  // room for a full two-record item
  assign room       = (count <= sst_pkg::REC_CNT_BITS'(sst_pkg::REC_FIFO_DEPTH - 2));
  assign count_next = count + sst_pkg::REC_CNT_BITS'(push_n)
                      - sst_pkg::REC_CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= in_rec0;
    end
    if (push_n == 2'd2) begin
      mem[sst_pkg::REC_PTR_BITS'(wr_ptr + 1'b1)] <= in_rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= sst_pkg::REC_PTR_BITS'(wr_ptr + push_n);
      if (pop) begin
        rd_ptr <= sst_pkg::REC_PTR_BITS'(rd_ptr + 1'b1);
      end
      count <= count_next;
    end
  end

  // Assertions
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= sst_pkg::REC_CNT_BITS'(sst_pkg::REC_FIFO_DEPTH))
    else $error("record queue overflow");

  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> room)
    else $error("push without room");

  a_pair_ends_run: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (in_rec1.last && !in_rec0.last))
    else $error("record pair has wrong end-of-run marks");

endmodule

[hw/rtl/source_text_tokenizer.sv]
// ============================================================================
// source_text_tokenizer: streaming lexical tokenizer for C-style source text
// Top level: input request register, scanner, output record queue.
// ============================================================================
// Accepts one request per clock while the queue has room: a source byte
// (s_tuser = 0) or an end-of-input marker (s_tuser = 1). A request is held in
// the input register, then the scanner resolves it in a single pass and drops
// zero, one or two token records into a four-entry output queue that feeds the
// master side. Sustained rate is one request per cycle while items average at
// most one record; an item that yields two records (a pending operator, number
// or identifier closed by a single-character or unknown byte, or any pending
// token plus the end record) leaves the queue record by record, so its drain
// rate of one record per cycle sets the long-run ceiling. s_tready stays high
// while the master side is stalled until the queue holds more than two records.
// Configuration writes (start_line, start_column) are always accepted; issue
// them only while the block is idle. They take effect at the next restart,
// and also at once while no byte has arrived since the last restart. No
// memory clearing is done after reset.
// ============================================================================
module source_text_tokenizer (
  input  logic                             clk,
  input  logic                             rst,
  // Request input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] char_byte
  input  logic                             s_tuser,   // [0] req_type
  // Token record output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sst_pkg::M_TDATA_BITS-1:0] m_tdata,   // token_line, token_column,
                                                      // token_position,
                                                      // lexeme_length, error_code,
                                                      // zero pad
  output logic                             m_tlast,   // last_of_run
  output logic [sst_pkg::KIND_BITS-1:0]    m_tuser,   // [5:0] token_kind
  // Configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [sst_pkg::LINE_BITS-1:0]    cfg_data
);

  // Input request register
  logic                          in_vld;
  logic                          in_type;
  logic [sst_pkg::CHAR_BITS-1:0] in_byte;

  logic                          step_fire;
  logic                          room;
  logic [1:0]                    rec_count;
  logic [1:0]                    push_n;
  sst_pkg::rec_t                 rec0;
  sst_pkg::rec_t                 rec1;
  sst_pkg::rec_t                 out_rec;
  sst_pkg::cfg_wr_t              cfg;

  // Step when the queue can take a worst-case two-record item
  assign step_fire = in_vld && room;
  assign s_tready  = !in_vld || step_fire;
  assign push_n    = step_fire ? rec_count : 2'd0;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (step_fire) begin
      in_vld <= 1'b0;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  sst_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step_en   (step_fire),
    .req_type  (in_type),
    .char_byte (in_byte),
    .cfg       (cfg),
    .rec0      (rec0),
    .rec1      (rec1),
    .rec_count (rec_count)
  );

  sst_rec_fifo u_rec_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .in_rec0   (rec0),
    .in_rec1   (rec1),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_rec   (out_rec)
  );

  // Output packing, first field in the low bits
  assign m_tlast = out_rec.last;
  assign m_tuser = out_rec.kind;
  assign m_tdata = sst_pkg::M_TDATA_BITS'({out_rec.error, out_rec.length, out_rec.position,
                                           out_rec.column, out_rec.line});

endmodule
